>>> src/assert_macros.svh
// Assertion macros used by the inertia tensor datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCIT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/pcit_pkg.sv
// Types, constants and arithmetic helpers of the inertia tensor block.
package pcit_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned SQ_W        = 2 * DIFF_W;
  localparam int unsigned TERM_W      = SQ_W + 1;
  localparam int unsigned ACC_W       = 51;
  localparam int unsigned MASS_W      = 16;
  localparam int unsigned OUT_W       = 48;
  localparam int unsigned PU_W        = 17;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned NUM_ENTRIES = 6;
  localparam int unsigned ENT_W       = 3;

  // magnitude multiply split into two partial products
  localparam int unsigned LO_W     = 26;
  localparam int unsigned PLO_W    = LO_W + MASS_W;
  localparam int unsigned PHI_W    = (ACC_W - LO_W) + MASS_W;
  localparam int unsigned SUM_W    = PHI_W + LO_W;
  localparam int unsigned PROD_W   = ACC_W + MASS_W - 1;
  localparam int unsigned FRAC_SH  = 8;
  localparam int unsigned QUOT_W   = PROD_W - FRAC_SH;
  localparam int unsigned STEP_W   = 6;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W - 1);

  localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(256);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_MASS = CFG_IDX_W'(3);

  // tensor entry order
  localparam logic [ENT_W-1:0] ENT_XX = ENT_W'(0);
  localparam logic [ENT_W-1:0] ENT_YY = ENT_W'(1);
  localparam logic [ENT_W-1:0] ENT_ZZ = ENT_W'(2);
  localparam logic [ENT_W-1:0] ENT_XY = ENT_W'(3);
  localparam logic [ENT_W-1:0] ENT_XZ = ENT_W'(4);
  localparam logic [ENT_W-1:0] ENT_YZ = ENT_W'(5);
  localparam logic [ENT_W-1:0] ENT_LAST = ENT_YZ;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [QUOT_W-1:0] QPOS_LIM = {{(QUOT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic [QUOT_W-1:0] QNEG_LIM = {{(QUOT_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_LOAD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV,
    ST_SAT,
    ST_PUBLISH
  } pcit_state_e;

  typedef struct packed {
    logic accept_en;
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic div_step;
    logic store;
    logic publish;
  } pcit_cmd_t;

  typedef struct packed {
    logic end_set;
    logic pipe_empty;
    logic div_done;
    logic entry_last;
    logic out_free;
  } pcit_sts_t;

  function automatic logic signed [TERM_W-1:0] ext_term(logic signed [SQ_W-1:0] v);
    return {v[SQ_W-1], v};
  endfunction

  // accumulate with saturation to the accumulator range
  function automatic logic [ACC_W-1:0] sat_acc(logic [ACC_W-1:0] acc,
                                               logic [TERM_W-1:0] term);
    logic [ACC_W:0] sum;
    sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-TERM_W){term[TERM_W-1]}}, term};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      return sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return sum[ACC_W-1:0];
  endfunction

  // apply sign to a quotient magnitude and clamp to the output range
  function automatic logic [OUT_W-1:0] sat_out(logic [QUOT_W-1:0] q, logic neg);
    if (neg) begin
      if (q > QNEG_LIM) begin
        return OUT_MIN;
      end
      return ~q[OUT_W-1:0] + 1'b1;
    end
    if (q > QPOS_LIM) begin
      return OUT_MAX;
    end
    return q[OUT_W-1:0];
  endfunction

endpackage

>>> src/pcit_ctrl.sv
// Sequencer of the inertia tensor block: accumulate, then scale six entries.
module pcit_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcit_pkg::pcit_sts_t  sts_i,
  output pcit_pkg::pcit_cmd_t  cmd_o
);

  pcit_pkg::pcit_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcit_pkg::ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcit_pkg::ST_ACCUM: begin
        if (sts_i.end_set) state_d = pcit_pkg::ST_FLUSH;
      end
      pcit_pkg::ST_FLUSH: begin
        if (sts_i.pipe_empty) state_d = pcit_pkg::ST_LOAD;
      end
      pcit_pkg::ST_LOAD:   state_d = pcit_pkg::ST_MUL_LO;
      pcit_pkg::ST_MUL_LO: state_d = pcit_pkg::ST_MUL_HI;
      pcit_pkg::ST_MUL_HI: state_d = pcit_pkg::ST_SUM;
      pcit_pkg::ST_SUM:    state_d = pcit_pkg::ST_DIV;
      pcit_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = pcit_pkg::ST_SAT;
      end
      pcit_pkg::ST_SAT: begin
        state_d = sts_i.entry_last ? pcit_pkg::ST_PUBLISH : pcit_pkg::ST_LOAD;
      end
      pcit_pkg::ST_PUBLISH: begin
        if (sts_i.out_free) state_d = pcit_pkg::ST_ACCUM;
      end
      default: state_d = pcit_pkg::ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      pcit_pkg::ST_ACCUM:   cmd_o.accept_en = 1'b1;
      pcit_pkg::ST_FLUSH:   cmd_o = '0;
      pcit_pkg::ST_LOAD:    cmd_o.load = 1'b1;
      pcit_pkg::ST_MUL_LO:  cmd_o.mul_lo = 1'b1;
      pcit_pkg::ST_MUL_HI:  cmd_o.mul_hi = 1'b1;
      pcit_pkg::ST_SUM:     cmd_o.sum = 1'b1;
      pcit_pkg::ST_DIV:     cmd_o.div_step = 1'b1;
      pcit_pkg::ST_SAT:     cmd_o.store = 1'b1;
      pcit_pkg::ST_PUBLISH: cmd_o.publish = sts_i.out_free;
      default:              cmd_o = '0;
    endcase
  end

endmodule

>>> src/pcit_dpath.sv
// Datapath: centring, moment accumulation, scaling multiply and divider.
`include "assert_macros.svh"

module pcit_dpath #(
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pcit_pkg::pcit_cmd_t                   cmd_i,
  output pcit_pkg::pcit_sts_t                   sts_o,
  input  logic                                  in_valid_i,
  input  logic signed [pcit_pkg::COORD_W-1:0]   pos_x_i,
  input  logic signed [pcit_pkg::COORD_W-1:0]   pos_y_i,
  input  logic signed [pcit_pkg::COORD_W-1:0]   pos_z_i,
  input  logic                                  last_point_i,
  input  logic signed [pcit_pkg::COORD_W-1:0]   center_x_i,
  input  logic signed [pcit_pkg::COORD_W-1:0]   center_y_i,
  input  logic signed [pcit_pkg::COORD_W-1:0]   center_z_i,
  input  logic        [pcit_pkg::MASS_W-1:0]    point_mass_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     ixx_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     iyy_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     izz_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     ixy_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     ixz_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     iyz_o,
  output logic        [pcit_pkg::PU_W-1:0]      points_used_o
);

  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_POINTS - 1);
  localparam logic [CntW-1:0] CntMax  = CntW'(MAX_POINTS);

  logic accept;

  // stage 1: offsets from centre
  logic                                 s1_v_q;
  logic signed [pcit_pkg::DIFF_W-1:0]   dx_d, dy_d, dz_d, dx_q, dy_q, dz_q;
  // stage 2: products
  logic                                 s2_v_q;
  logic signed [pcit_pkg::SQ_W-1:0]     pxx_d, pyy_d, pzz_d, pxy_d, pxz_d, pyz_d;
  logic signed [pcit_pkg::SQ_W-1:0]     pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;
  logic        [pcit_pkg::TERM_W-1:0]   term_d [pcit_pkg::NUM_ENTRIES];
  logic        [pcit_pkg::ACC_W-1:0]    acc_q  [pcit_pkg::NUM_ENTRIES];

  logic [CntW-1:0]                      cnt_q;
  logic [CntW+pcit_pkg::PU_W-1:0]       cnt_ext;
  logic [pcit_pkg::ENT_W-1:0]           k_q;

  // scaling
  logic [pcit_pkg::ACC_W:0]             acc_ext, mag_full;
  logic [pcit_pkg::ACC_W-1:0]           mag_q;
  logic                                 neg_q;
  logic [pcit_pkg::PLO_W-1:0]           plo_q;
  logic [pcit_pkg::PHI_W-1:0]           phi_q;
  logic [pcit_pkg::SUM_W-1:0]           sum_d;

  // divider
  logic [pcit_pkg::QUOT_W-1:0]          dq_q;
  logic [CntW-1:0]                      rem_q;
  logic [CntW:0]                        trial, diff;
  logic                                 ge;
  logic [pcit_pkg::STEP_W-1:0]          step_q;

  logic [pcit_pkg::OUT_W-1:0]           res_q [pcit_pkg::NUM_ENTRIES];
  logic                                 out_valid_q;

  assign accept = in_valid_i & cmd_i.accept_en;

  assign dx_d = $signed({pos_x_i[pcit_pkg::COORD_W-1], pos_x_i})
              - $signed({center_x_i[pcit_pkg::COORD_W-1], center_x_i});
  assign dy_d = $signed({pos_y_i[pcit_pkg::COORD_W-1], pos_y_i})
              - $signed({center_y_i[pcit_pkg::COORD_W-1], center_y_i});
  assign dz_d = $signed({pos_z_i[pcit_pkg::COORD_W-1], pos_z_i})
              - $signed({center_z_i[pcit_pkg::COORD_W-1], center_z_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
    end
  end

  assign pxx_d = dx_q * dx_q;
  assign pyy_d = dy_q * dy_q;
  assign pzz_d = dz_q * dz_q;
  assign pxy_d = dx_q * dy_q;
  assign pxz_d = dx_q * dz_q;
  assign pyz_d = dy_q * dz_q;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      pxx_q <= pxx_d;
      pyy_q <= pyy_d;
      pzz_q <= pzz_d;
      pxy_q <= pxy_d;
      pxz_q <= pxz_d;
      pyz_q <= pyz_d;
    end
  end

  always_comb begin
    term_d[pcit_pkg::ENT_XX] = pcit_pkg::ext_term(pyy_q) + pcit_pkg::ext_term(pzz_q);
    term_d[pcit_pkg::ENT_YY] = pcit_pkg::ext_term(pxx_q) + pcit_pkg::ext_term(pzz_q);
    term_d[pcit_pkg::ENT_ZZ] = pcit_pkg::ext_term(pxx_q) + pcit_pkg::ext_term(pyy_q);
    term_d[pcit_pkg::ENT_XY] = -pcit_pkg::ext_term(pxy_q);
    term_d[pcit_pkg::ENT_XZ] = -pcit_pkg::ext_term(pxz_q);
    term_d[pcit_pkg::ENT_YZ] = -pcit_pkg::ext_term(pyz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '{default: '0};
    end else if (cmd_i.publish) begin
      acc_q <= '{default: '0};
    end else if (s2_v_q) begin
      for (int e = 0; e < pcit_pkg::NUM_ENTRIES; e++) begin
        acc_q[e] <= pcit_pkg::sat_acc(acc_q[e], term_d[e]);
      end
    end
  end

  // point count, entry index and divide step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      k_q    <= '0;
      step_q <= '0;
    end else begin
      if (cmd_i.publish) begin
        cnt_q <= '0;
      end else if (accept) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.publish) begin
        k_q <= '0;
      end else if (cmd_i.store) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.sum) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  assign cnt_ext = {{pcit_pkg::PU_W{1'b0}}, cnt_q};

  // magnitude, then |S| * mass in two partial products
  assign acc_ext  = {acc_q[k_q][pcit_pkg::ACC_W-1], acc_q[k_q]};
  assign mag_full = acc_ext[pcit_pkg::ACC_W] ? (~acc_ext + 1'b1) : acc_ext;
  assign sum_d    = {{(pcit_pkg::SUM_W - pcit_pkg::PLO_W){1'b0}}, plo_q}
                  + {phi_q, {pcit_pkg::LO_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_full[pcit_pkg::ACC_W-1:0];
      neg_q <= acc_ext[pcit_pkg::ACC_W];
    end
    if (cmd_i.mul_lo) begin
      plo_q <= mag_q[pcit_pkg::LO_W-1:0] * point_mass_i;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= mag_q[pcit_pkg::ACC_W-1:pcit_pkg::LO_W] * point_mass_i;
    end
  end

  // restoring divide by the point count, one quotient bit a cycle
  assign trial = {rem_q, dq_q[pcit_pkg::QUOT_W-1]};
  assign diff  = trial - {1'b0, cnt_q};
  assign ge    = trial >= {1'b0, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      dq_q  <= sum_d[pcit_pkg::PROD_W-1:pcit_pkg::FRAC_SH];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[pcit_pkg::QUOT_W-2:0], ge};
      rem_q <= ge ? diff[CntW-1:0] : trial[CntW-1:0];
    end
    if (cmd_i.store) begin
      res_q[k_q] <= pcit_pkg::sat_out(dq_q, neg_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      ixx_o         <= res_q[pcit_pkg::ENT_XX];
      iyy_o         <= res_q[pcit_pkg::ENT_YY];
      izz_o         <= res_q[pcit_pkg::ENT_ZZ];
      ixy_o         <= res_q[pcit_pkg::ENT_XY];
      ixz_o         <= res_q[pcit_pkg::ENT_XZ];
      iyz_o         <= res_q[pcit_pkg::ENT_YZ];
      points_used_o <= cnt_ext[pcit_pkg::PU_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.end_set    = accept & (last_point_i | (cnt_q == CntLast));
  assign sts_o.pipe_empty = ~s1_v_q & ~s2_v_q;
  assign sts_o.div_done   = step_q == pcit_pkg::STEP_LAST;
  assign sts_o.entry_last = k_q == pcit_pkg::ENT_LAST;
  assign sts_o.out_free   = ~out_valid_q | ~out_stall_i;

  `PCIT_ASSERT_IMPL(a_load_pipe_empty, clk_i, rst_ni, cmd_i.load, !s1_v_q && !s2_v_q, "scaling started with points in flight")
  `PCIT_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, cmd_i.div_step, cnt_q != '0, "divide by zero point count")
  `PCIT_ASSERT_NEXT(a_store_done, clk_i, rst_ni, cmd_i.div_step && sts_o.div_done, cmd_i.store, "final divide step not followed by store")
  `PCIT_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntMax, "point count beyond set limit")

endmodule

>>> src/point_cloud_inertia_tensor.sv
// Inertia tensor of a stream of equal point masses: top level.
//
// Points enter on the input channel (in_valid_i / in_stall_o), one beat per
// point, with last_point_i on the final beat of a set. The centre and point
// mass are set through the configuration channel (cfg_valid_i / cfg_ready_o,
// index 0..3: centre x, y, z, mass; other indexes are dropped), always ready.
// Within a set one point is taken every cycle. After the closing beat, or the
// beat that brings the count to MAX_POINTS, the input stalls while each of the
// six entries runs through a multiply in two partial products and a
// bit-serial divide by the point count. The result sits in an output
// register (out_valid_o / out_stall_i); the next set is taken while it
// waits, and a further result waits internally until it has been taken.
// Reset clears the accumulators, the count and the output valid flag, and
// restores centre 0 and mass 1.0.
module point_cloud_inertia_tensor #(
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pcit_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pcit_pkg::MASS_W-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [pcit_pkg::COORD_W-1:0]   pos_x_i,
  input  logic signed [pcit_pkg::COORD_W-1:0]   pos_y_i,
  input  logic signed [pcit_pkg::COORD_W-1:0]   pos_z_i,
  input  logic                                  last_point_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pcit_pkg::OUT_W-1:0]     ixx_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     iyy_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     izz_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     ixy_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     ixz_o,
  output logic signed [pcit_pkg::OUT_W-1:0]     iyz_o,
  output logic        [pcit_pkg::PU_W-1:0]      points_used_o
);

  pcit_pkg::pcit_cmd_t cmd;
  pcit_pkg::pcit_sts_t sts;

  logic                                cfg_we;
  logic signed [pcit_pkg::COORD_W-1:0] center_x_q, center_y_q, center_z_q;
  logic        [pcit_pkg::MASS_W-1:0]  point_mass_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      center_z_q   <= '0;
      point_mass_q <= pcit_pkg::MASS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        pcit_pkg::CFG_CENTER_X:   center_x_q   <= cfg_data_i;
        pcit_pkg::CFG_CENTER_Y:   center_y_q   <= cfg_data_i;
        pcit_pkg::CFG_CENTER_Z:   center_z_q   <= cfg_data_i;
        pcit_pkg::CFG_POINT_MASS: point_mass_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = ~cmd.accept_en;

  pcit_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pcit_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_valid_i    (in_valid_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .last_point_i  (last_point_i),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .center_z_i    (center_z_q),
    .point_mass_i  (point_mass_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .ixx_o         (ixx_o),
    .iyy_o         (iyy_o),
    .izz_o         (izz_o),
    .ixy_o         (ixy_o),
    .ixz_o         (ixz_o),
    .iyz_o         (iyz_o),
    .points_used_o (points_used_o)
  );

endmodule
